### design/fin_pkg.sv
// Package for the flux interval normalizer: field widths, operation codes
// and reset constants shared by the channels, the serial units and the top level.
// No dependencies.
package fin_pkg;

  localparam int TIME_BITS = 28;
  localparam int SUM_BITS  = 32;
  localparam int PROD_BITS = 2 * TIME_BITS;
  localparam int CNT_BITS  = $clog2(TIME_BITS + 1);
  localparam int OP_BITS   = 2;

  localparam logic [TIME_BITS-1:0] TIME_MAX  = {TIME_BITS{1'b1}};
  localparam logic [TIME_BITS-1:0] REV_RESET = TIME_BITS'(200000000);

  localparam logic [OP_BITS-1:0] OP_SUM    = 2'd0;
  localparam logic [OP_BITS-1:0] OP_SCALE  = 2'd1;
  localparam logic [OP_BITS-1:0] OP_FINISH = 2'd2;

endpackage

### design/fin_channels.sv
// Valid/ready channels of the flux interval normalizer: request, result and
// configuration write. Depends on fin_pkg for the field widths.
interface fin_req_if;
  import fin_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OP_BITS-1:0]   op;
  logic [TIME_BITS-1:0] cell_time;
  modport source (output valid, output op, output cell_time, input ready);
  modport sink (input valid, input op, input cell_time, output ready);
endinterface

interface fin_res_if;
  import fin_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] scaled_time;
  logic                 orientation;
  logic                 padding_cell;
  logic                 divide_error;
  modport source (output valid, output scaled_time, output orientation,
                  output padding_cell, output divide_error, input ready);
  modport sink (input valid, input scaled_time, input orientation,
                input padding_cell, input divide_error, output ready);
endinterface

interface fin_cfg_if;
  import fin_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/flux_interval_normalizer_unit.sv
// Top level of the flux interval normalizer: request handling, track state,
// result register and the serial multiply/divide datapath.
// Depends on fin_pkg, fin_channels, fin_mul and fin_div.
//
//   Channel | Direction | Payload                                        | Handshake
//   --------+-----------+------------------------------------------------+-----------
//   cfg     | in        | data: revolution total (28 b)                  | valid/ready
//   req     | in        | op (2 b), cell_time (28 b)                     | valid/ready
//   res     | out       | scaled_time (28 b), orientation, padding_cell, | valid/ready
//           |           | divide_error                                   |
//
// A sum request, or one with the unused code, leaves the block idle. A scale
// request with a nonzero sum runs the bit-serial multiply (load, then one step per
// multiplier bit) and the radix-2 divide, then loads the quotient and hands it to the
// result register. A saturating quotient ends the divide right after its load; a scale
// request with a zero sum, like a finish request, goes straight to the result stage.
// The multiplier and divider loops handle one bit per cycle each.
// Reset (rst, synchronous) clears the sums, the orientation and the result
// valid flag, and loads the revolution total with 200000000.
// A stalled result holds in the output register; new requests are still taken
// while it waits, and only the hand-off of a new result waits for the slot.
module flux_interval_normalizer_unit (
  input  logic      clk,
  input  logic      rst,
  fin_cfg_if.sink   cfg,
  fin_req_if.sink   req,
  fin_res_if.source res
);
  import fin_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]           state;
  logic [1:0]           state_next;
  logic [OP_BITS-1:0]   cur_op;
  logic                 err_flag;
  logic [TIME_BITS-1:0] q_res;
  logic [TIME_BITS-1:0] rev_total;
  logic [SUM_BITS-1:0]  input_sum;
  logic [SUM_BITS-1:0]  emitted_sum;
  logic                 toggle;

  logic                 res_valid;
  logic [TIME_BITS-1:0] res_time;
  logic                 res_orient;
  logic                 res_pad;
  logic                 res_err;

  logic                 req_fire;
  logic                 slot_free;
  logic                 emit_fire;
  logic                 mul_start;
  logic                 mul_done;
  logic [PROD_BITS-1:0] product;
  logic                 div_done;
  logic [TIME_BITS-1:0] quotient;
  logic [SUM_BITS-1:0]  rev_wide;
  logic [SUM_BITS-1:0]  shortfall;
  logic                 short;

  // The configuration register is always writable; writes must come only while idle, which the block does not enforce.
  assign cfg.ready = 1'b1;

  assign req.ready = (state == ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign slot_free = !res_valid || res.ready;
  assign emit_fire = (state == ST_EMIT) && slot_free;

  // A scale request with a nonzero sum goes through multiply and divide;
  // with a zero sum it goes straight to the result stage with an error.
  assign mul_start = req_fire && (req.op == OP_SCALE) && (input_sum != '0);

  assign rev_wide  = SUM_BITS'(rev_total);
  assign short     = emitted_sum < rev_wide;
  assign shortfall = rev_wide - emitted_sum;

  fin_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (rev_total),
    .mplier  (req.cell_time),
    .done    (mul_done),
    .product (product)
  );

  fin_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (mul_done),
    .dividend (product),
    .divisor  (input_sum),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_fire) begin
          if (mul_start) begin
            state_next = ST_MUL;
          end else if (req.op == OP_SCALE || req.op == OP_FINISH) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state and track totals.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      rev_total   <= REV_RESET;
      input_sum   <= '0;
      emitted_sum <= '0;
      toggle      <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        rev_total <= cfg.data;
      end
      if (req_fire && req.op == OP_SUM) begin
        input_sum <= input_sum + SUM_BITS'(req.cell_time);
      end
      // A scaled interval always loads the result register; a finish loads it
      // only when the emitted total falls short of the target.
      if (emit_fire && (cur_op == OP_SCALE || short)) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
      if (emit_fire) begin
        if (cur_op == OP_SCALE) begin
          toggle      <= ~toggle;
          emitted_sum <= emitted_sum + SUM_BITS'(q_res);
        end else begin
          // Finish: the track state starts over, pad or no pad.
          input_sum   <= '0;
          emitted_sum <= '0;
          toggle      <= 1'b0;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      cur_op   <= req.op;
      err_flag <= (input_sum == '0);
      q_res    <= '0;
    end else if (state == ST_DIV && div_done) begin
      q_res <= quotient;
    end
    if (emit_fire) begin
      if (cur_op == OP_SCALE) begin
        res_time   <= q_res;
        res_orient <= ~toggle;
        res_pad    <= 1'b0;
        res_err    <= err_flag;
      end else begin
        // The shortfall is below the 28-bit total, so it never needs clamping.
        res_time   <= shortfall[TIME_BITS-1:0];
        res_orient <= toggle;
        res_pad    <= 1'b1;
        res_err    <= 1'b0;
      end
    end
  end

  assign res.valid        = res_valid;
  assign res.scaled_time  = res_time;
  assign res.orientation  = res_orient;
  assign res.padding_cell = res_pad;
  assign res.divide_error = res_err;

endmodule

### design/fin_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on fin_pkg.
module fin_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [fin_pkg::TIME_BITS-1:0] mcand,
  input  logic [fin_pkg::TIME_BITS-1:0] mplier,
  output logic                          done,
  output logic [fin_pkg::PROD_BITS-1:0] product
);
  import fin_pkg::*;

  logic                 busy;
  logic [CNT_BITS-1:0]  cnt;
  logic [TIME_BITS-1:0] mcand_r;
  logic [PROD_BITS-1:0] acc;
  logic [TIME_BITS:0]   partial;

  // The upper half gathers partial products while the multiplier bits
  // shift out of the lower half.
  assign partial = {1'b0, acc[PROD_BITS-1:TIME_BITS]}
                 + (acc[0] ? {1'b0, mcand_r} : {(TIME_BITS+1){1'b0}});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(TIME_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r <= mcand;
      acc     <= {{TIME_BITS{1'b0}}, mplier};
    end else if (busy) begin
      acc <= {partial, acc[TIME_BITS-1:1]};
    end
  end

  assign product = acc;

endmodule

### design/fin_div.sv
// Radix-2 restoring divider with saturation: one quotient bit per cycle.
// Depends on fin_pkg.
module fin_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [fin_pkg::PROD_BITS-1:0] dividend,
  input  logic [fin_pkg::SUM_BITS-1:0]  divisor,
  output logic                          done,
  output logic [fin_pkg::TIME_BITS-1:0] quotient
);
  import fin_pkg::*;

  logic                 busy;
  logic                 sat;
  logic [CNT_BITS-1:0]  cnt;
  logic [SUM_BITS-1:0]  divisor_r;
  logic [SUM_BITS-1:0]  rem;
  logic [TIME_BITS-1:0] low;
  logic [SUM_BITS:0]    trial;
  logic [SUM_BITS:0]    diff;
  logic                 fits;
  logic                 too_big;

  // The quotient needs more than TIME_BITS bits exactly when the upper half
  // of the dividend is not below the divisor.
  assign too_big = SUM_BITS'(dividend[PROD_BITS-1:TIME_BITS]) >= divisor;

  assign trial = {rem, low[TIME_BITS-1]};
  assign diff  = trial - {1'b0, divisor_r};
  assign fits  = trial >= {1'b0, divisor_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= !too_big;
        done <= too_big;
        cnt  <= CNT_BITS'(TIME_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sat       <= too_big;
      divisor_r <= divisor;
      rem       <= SUM_BITS'(dividend[PROD_BITS-1:TIME_BITS]);
      low       <= dividend[TIME_BITS-1:0];
    end else if (busy) begin
      rem <= fits ? diff[SUM_BITS-1:0] : trial[SUM_BITS-1:0];
      low <= {low[TIME_BITS-2:0], fits};
    end
  end

  assign quotient = sat ? TIME_MAX : low;

endmodule

### design/fin_check.sv
// Port-level checker for the flux interval normalizer, bound to the top level.
// Depends on fin_pkg and flux_interval_normalizer_unit.
module fin_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic [fin_pkg::OP_BITS-1:0]   req_op,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [fin_pkg::TIME_BITS-1:0] res_scaled_time,
  input logic                          res_orientation,
  input logic                          res_padding_cell,
  input logic                          res_divide_error
);
  import fin_pkg::*;

  // A stalled result keeps its value.
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_scaled_time)
      && $stable(res_orientation) && $stable(res_padding_cell)
      && $stable(res_divide_error)))
    else $error("stalled result changed");

  // A pad cell never carries a divide error.
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_padding_cell && res_divide_error))
    else $error("pad cell flagged with divide error");

  // A divide error always comes with a zero length.
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_divide_error) |-> (res_scaled_time == '0))
    else $error("divide error with nonzero length");

  // A scale request keeps the block busy for at least the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_op == OP_SCALE) |=> !req_ready)
    else $error("scale request did not occupy the block");

  // A new result appears only out of a busy cycle.
  assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> !$past(req_ready))
    else $error("result appeared while idle");

endmodule

bind flux_interval_normalizer_unit fin_check u_fin_check (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .req_op           (req.op),
  .res_valid        (res.valid),
  .res_ready        (res.ready),
  .res_scaled_time  (res.scaled_time),
  .res_orientation  (res.orientation),
  .res_padding_cell (res.padding_cell),
  .res_divide_error (res.divide_error)
);

### tb/fin_track_rescaler_pkg.sv
// Track rescaler for the flux interval normalizer bench: tracks the sums and the
// orientation, works out each normalized or padding cell, and checks arriving cells.
// Depends on fin_pkg for widths, operation codes and the reset target.
package fin_track_rescaler_pkg;
  import fin_pkg::*;

  // The fourth operation code has no meaning; the block must ignore it.
  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [TIME_BITS-1:0] scaled_time;
    logic                 orientation;
    logic                 padding_cell;
    logic                 divide_error;
  } flux_cell_t;

  class track_rescaler;
    logic [TIME_BITS-1:0] rev_total;
    logic [SUM_BITS-1:0]  input_total;
    logic [SUM_BITS-1:0]  emitted_total;
    logic                 last_orientation;
    flux_cell_t           due_cells[$];
    int mismatches;
    int sum_reqs, scale_reqs, finish_reqs, unused_reqs;
    int cells_checked, pads, zero_flags, saturated, total_writes;

    function new();
      rev_total = REV_RESET;
      clear_track();
    endfunction

    function void clear_track();
      input_total      = '0;
      emitted_total    = '0;
      last_orientation = 1'b0;
    endfunction

    function void set_total(logic [TIME_BITS-1:0] value);
      rev_total = value;
      total_writes++;
    endfunction

    function void take_request(logic [OP_BITS-1:0] op, logic [TIME_BITS-1:0] cell_time);
      logic [63:0]         quotient;
      logic [SUM_BITS-1:0] shortfall;
      flux_cell_t          outcome;
      case (op)
        OP_SUM: begin
          input_total += SUM_BITS'(cell_time);
          sum_reqs++;
        end
        OP_SCALE: begin
          scale_reqs++;
          last_orientation     = ~last_orientation;
          outcome.orientation  = last_orientation;
          outcome.padding_cell = 1'b0;
          outcome.divide_error = 1'b0;
          if (input_total == '0) begin
            quotient             = '0;
            outcome.divide_error = 1'b1;
            zero_flags++;
          end else begin
            quotient = (64'(rev_total) * 64'(cell_time)) / 64'(input_total);
            if (quotient > 64'(TIME_MAX)) begin
              quotient = 64'(TIME_MAX);
              saturated++;
            end
          end
          emitted_total      += quotient[SUM_BITS-1:0];
          outcome.scaled_time = quotient[TIME_BITS-1:0];
          due_cells = {due_cells, outcome};
        end
        OP_FINISH: begin
          finish_reqs++;
          if (emitted_total < SUM_BITS'(rev_total)) begin
            shortfall = SUM_BITS'(rev_total) - emitted_total;
            if (shortfall > SUM_BITS'(TIME_MAX))
              shortfall = SUM_BITS'(TIME_MAX);
            outcome.scaled_time  = shortfall[TIME_BITS-1:0];
            outcome.orientation  = last_orientation;
            outcome.padding_cell = 1'b1;
            outcome.divide_error = 1'b0;
            due_cells = {due_cells, outcome};
            pads++;
          end
          clear_track();
        end
        default: unused_reqs++;
      endcase
    endfunction

    function void compare_field(string name, logic [TIME_BITS-1:0] want,
                                logic [TIME_BITS-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_cell(flux_cell_t got);
      flux_cell_t want;
      if (due_cells.size() == 0) begin
        $error("unexpected result: scaled_time %0d with nothing outstanding",
               got.scaled_time);
        mismatches++;
        return;
      end
      want = due_cells.pop_front();
      cells_checked++;
      compare_field("scaled_time", want.scaled_time, got.scaled_time);
      compare_field("orientation", TIME_BITS'(want.orientation),
                    TIME_BITS'(got.orientation));
      compare_field("padding_cell", TIME_BITS'(want.padding_cell),
                    TIME_BITS'(got.padding_cell));
      compare_field("divide_error", TIME_BITS'(want.divide_error),
                    TIME_BITS'(got.divide_error));
    endfunction

    function int outstanding();
      return due_cells.size();
    endfunction

    function void flag_leftover();
      if (due_cells.size() != 0) begin
        $error("%0d expected results never arrived", due_cells.size());
        mismatches++;
      end
    endfunction
  endclass

endpackage

### tb/flux_interval_normalizer_unit_tb.sv
// Self-checking bench for flux_interval_normalizer_unit: random two-pass tracks
// under varying handshake pressure, checked cell by cell against a track rescaler.
// Depends on fin_pkg, fin_channels, the design and fin_track_rescaler_pkg.
module flux_interval_normalizer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fin_pkg::*;
  import fin_track_rescaler_pkg::*;

  // Cycles with no handshake on any channel before the run is declared hung.
  // This leaves a wide margin over a scale request plus random stalls on either side.
  localparam int STALL_LIMIT   = 4000;
  // Quiet time after the last expected cell, so that a sum request or a finish
  // without a pad, which leave nothing to wait for, has surely completed.
  localparam int SETTLE_CYCLES = 80;
  localparam int RANDOM_ITEMS  = 390;
  localparam int SEGMENTS      = 6;

  // Interval magnitudes: the full field, tiny values, values of random width,
  // and values just under the maximum that bring the 32-bit sum near its wrap.
  typedef enum {SPAN_FULL, SPAN_SMALL, SPAN_SCALED, SPAN_TOP} span_t;

  logic clk;
  logic rst;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   items_sent;
  int   stall_cycles;

  fin_cfg_if cfg_bus();
  fin_req_if req_bus();
  fin_res_if res_bus();

  track_rescaler rescaler = new();

  flux_interval_normalizer_unit dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_bus),
    .req (req_bus),
    .res (res_bus)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The result side stalls at random; the main sequence sets how often.
  always @(posedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Every accepted cell is compared with the oldest one still outstanding.
  always @(posedge clk) begin : watch_results
    flux_cell_t seen;
    if (!rst && res_bus.valid && res_bus.ready) begin
      seen.scaled_time  = res_bus.scaled_time;
      seen.orientation  = res_bus.orientation;
      seen.padding_cell = res_bus.padding_cell;
      seen.divide_error = res_bus.divide_error;
      rescaler.check_cell(seen);
    end
  end

  // Hang detection: any handshake on any channel restarts the count.
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic logic [TIME_BITS-1:0] pick_interval(span_t span);
    logic [TIME_BITS-1:0] raw;
    raw = TIME_BITS'($urandom);
    case (span)
      SPAN_SMALL:  return TIME_BITS'($urandom_range(0, 1023));
      SPAN_SCALED: return raw >> $urandom_range(0, TIME_BITS - 1);
      SPAN_TOP:    return TIME_MAX - TIME_BITS'($urandom_range(0, 63));
      default:     return raw;
    endcase
  endfunction

  // Presents one request and returns at the edge where it is accepted. The
  // valid line is left high, so back-to-back requests need no gap; whoever
  // stops sending next must lower it.
  task automatic send_request(input logic [OP_BITS-1:0] op,
                              input logic [TIME_BITS-1:0] cell_time);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid     <= 1'b1;
    req_bus.op        <= op;
    req_bus.cell_time <= cell_time;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    rescaler.take_request(op, cell_time);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // Stops sending and waits until every expected cell has come back. It
  // always advances at least one cycle, so the valid line is never lowered
  // and raised again in the same time step.
  task automatic drain_results();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (rescaler.outstanding() != 0);
  endtask

  // The target register may only change while the block is idle.
  task automatic write_total(input logic [TIME_BITS-1:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    rescaler.set_total(value);
  endtask

  // A well-formed track: the summing pass, the same intervals again for the
  // scaling pass, then the finish request.
  task automatic run_clean_track();
    logic [TIME_BITS-1:0] cells[$];
    int                   count;
    span_t                span;
    count = $urandom_range(1, 10);
    span  = span_t'($urandom_range(0, 3));
    repeat (count) begin
      cells = {cells, pick_interval(span)};
      send_request(OP_SUM, cells[$]);
    end
    foreach (cells[i]) send_request(OP_SCALE, cells[i]);
    send_request(OP_FINISH, pick_interval(SPAN_FULL));
  endtask

  // A malformed track: the passes disagree in length and content, stray
  // operation codes slip in, and the finish is sometimes missing.
  task automatic run_broken_track();
    logic [OP_BITS-1:0] op;
    repeat ($urandom_range(0, 6))
      send_request(OP_SUM, pick_interval(span_t'($urandom_range(0, 3))));
    repeat ($urandom_range(0, 6)) begin
      op = ($urandom_range(0, 5) == 0) ? OP_BITS'($urandom_range(0, 3)) : OP_SCALE;
      send_request(op, pick_interval(span_t'($urandom_range(0, 3))));
    end
    if ($urandom_range(0, 3) != 0) send_request(OP_FINISH, pick_interval(SPAN_FULL));
  endtask

  // Sixteen near-maximum intervals bring the 32-bit sum just under its wrap
  // point. Half the time a closing interval wraps it to exactly zero, so the
  // scaling pass sees a zero sum although intervals were added; otherwise the
  // closing interval is small and random and may carry the sum past the wrap.
  task automatic run_wrap_track();
    logic [TIME_BITS-1:0] cells[$];
    logic [SUM_BITS-1:0]  running;
    logic [SUM_BITS-1:0]  closing;
    running = '0;
    repeat (16) begin
      cells = {cells, pick_interval(SPAN_TOP)};
      running += SUM_BITS'(cells[$]);
      send_request(OP_SUM, cells[$]);
    end
    closing = ($urandom_range(0, 1) == 0) ? SUM_BITS'(0) - running
                                          : SUM_BITS'($urandom_range(0, 4095));
    send_request(OP_SUM, closing[TIME_BITS-1:0]);
    repeat ($urandom_range(1, 3))
      send_request(OP_SCALE, cells[$urandom_range(0, 15)]);
    send_request(OP_FINISH, pick_interval(SPAN_FULL));
  endtask

  task automatic run_noise();
    repeat ($urandom_range(1, 4))
      send_request(OP_BITS'($urandom_range(0, 3)), pick_interval(span_t'($urandom_range(0, 3))));
  endtask

  task automatic run_track();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      run_clean_track();
    end else if (pick < 80) begin
      run_broken_track();
    end else if (pick < 88) begin
      run_wrap_track();
    end else begin
      run_noise();
    end
  endtask

  initial begin : main_sequence
    int                   seg_goal;
    logic [TIME_BITS-1:0] seg_total;
    rst               <= 1'b1;
    req_bus.valid     <= 1'b0;
    req_bus.op        <= OP_SUM;
    req_bus.cell_time <= '0;
    cfg_bus.valid     <= 1'b0;
    cfg_bus.data      <= '0;
    items_sent        = 0;
    send_idle_pct     = 29;
    recv_idle_pct     = 59;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part, run with the target left at its reset value.
    // Scaling before anything was summed raises the divide error, and the
    // orientation still flips to one; the finish then pads the whole target.
    send_request(OP_SCALE, TIME_MAX);
    send_request(OP_FINISH, TIME_MAX);
    // A sum of one: a zero interval scales to zero, a unit interval to the
    // full target, and the largest interval saturates. The stray operation
    // code in between must change nothing. The overshoot means no pad.
    send_request(OP_SUM, '0);
    send_request(OP_SUM, TIME_BITS'(1));
    send_request(OP_UNUSED, TIME_MAX);
    send_request(OP_SCALE, '0);
    send_request(OP_SCALE, TIME_BITS'(1));
    send_request(OP_SCALE, TIME_MAX);
    send_request(OP_FINISH, '0);
    // One maximal interval scales to exactly the target: no pad follows.
    send_request(OP_SUM, TIME_MAX);
    send_request(OP_SCALE, TIME_MAX);
    send_request(OP_FINISH, '0);
    // Part of the track scaled, so the finish pads out the shortfall.
    send_request(OP_SUM, TIME_BITS'(5));
    send_request(OP_SCALE, TIME_BITS'(2));
    send_request(OP_FINISH, '0);
    // Alternating bit patterns through both passes.
    send_request(OP_SUM, 28'h5555555);
    send_request(OP_SUM, 28'hAAAAAAA);
    send_request(OP_SCALE, 28'hAAAAAAA);
    send_request(OP_SCALE, 28'h5555555);
    send_request(OP_FINISH, 28'h5555555);

    // Random part in six segments, each with its own target; the idle
    // pattern moves from a slow receiver to a slow sender to none at all.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 2) begin
        send_idle_pct = 29;
        recv_idle_pct = 59;
      end else if (seg < 4) begin
        send_idle_pct = 59;
        recv_idle_pct = 29;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (seg)
        0:       seg_total = TIME_MAX;
        1:       seg_total = TIME_BITS'(1);
        2:       seg_total = TIME_BITS'($urandom);
        3:       seg_total = '0;
        4:       seg_total = TIME_BITS'($urandom_range(1, 4095));
        default: seg_total = REV_RESET;
      endcase
      write_total(seg_total);
      seg_goal = items_sent + RANDOM_ITEMS / SEGMENTS;
      while (items_sent < seg_goal) begin
        // Now and then the sender holds off until every cell is back.
        if ($urandom_range(0, 24) == 0) drain_results();
        run_track();
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    rescaler.flag_leftover();

    $display("Covered %0d sum, %0d scale and %0d finish requests, %0d unused codes,",
             rescaler.sum_reqs, rescaler.scale_reqs, rescaler.finish_reqs,
             rescaler.unused_reqs);
    $display("%0d targets; checked %0d cells: %0d pads, %0d zero-sum flags, %0d saturated.",
             rescaler.total_writes, rescaler.cells_checked, rescaler.pads,
             rescaler.zero_flags, rescaler.saturated);
    if (rescaler.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
design/fin_pkg.sv
design/fin_channels.sv
design/fin_mul.sv
design/fin_div.sv
design/flux_interval_normalizer_unit.sv
design/fin_check.sv
tb/fin_track_rescaler_pkg.sv
tb/flux_interval_normalizer_unit_tb.sv
